[sv/slpb_pkg.sv]
// ----------------------------------------------------------------------------
// slpb_pkg
// shared types, constants and the control store of the segmented pixel buffer
// ----------------------------------------------------------------------------
package slpb_pkg;

  // sizing
  localparam int MAX_NODES  = 16;
  localparam int MAX_LEDS   = 8;
  localparam int COLOR_BITS = 32;
  localparam int DEPTH      = MAX_NODES * MAX_LEDS;

  localparam int NODE_W = 4;                        // node_sel field
  localparam int POS_W  = 3;                        // led_pos field
  localparam int CNT_W  = $clog2(MAX_LEDS + 1);     // pixel count, cursor, index
  localparam int NN_W   = $clog2(MAX_NODES + 1);    // node count
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PC_W   = 6;

  // port payload widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [NN_W-1:0]       nn_t;
  typedef logic [PC_W-1:0]       pc_t;

  // command kinds
  typedef enum logic [2:0] {
    K_SET      = 3'd0,
    K_PUSH     = 3'd1,
    K_POP      = 3'd2,
    K_FILL     = 3'd3,
    K_FILL_ALL = 3'd4,
    K_LIST     = 3'd5,
    K_READ     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_NODE = 2'd1,
    ST_BAD_POS  = 2'd2
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NODE_TOTAL = 1'b0,
    REG_LEDS       = 1'b1
  } cfg_reg_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_REQ,
    C_KIND,
    C_BAD_NODE,
    C_BAD_POS,
    C_NL_ZERO,
    C_CNT_MORE,
    C_CUR_FULL,
    C_NO_PAD,
    C_IDX_END,
    C_IDX_MORE,
    C_NODE_LAST,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_POS, IDX_START, IDX_STEP, IDX_INC, IDX_CURSOR
  } idx_op_e;

  typedef enum logic {WA_IDX, WA_PREV} wa_sel_e;
  typedef enum logic [1:0] {WD_COLOR, WD_PAD, WD_CARRY} wd_sel_e;
  typedef enum logic [1:0] {CARRY_HOLD, CARRY_COLOR, CARRY_RDATA} carry_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_NL, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {NODE_HOLD, NODE_ZERO, NODE_INC, NODE_LIST} node_op_e;
  typedef enum logic [1:0] {CUR_HOLD, CUR_INC, CUR_CLR_LAST} cursor_op_e;
  typedef enum logic [1:0] {RDV_HOLD, RDV_RDATA, RDV_POP} rdv_op_e;
  typedef enum logic [1:0] {ST_HOLD, ST_SET_NODE, ST_SET_POS} st_op_e;

  // one control word
  typedef struct packed {
    cond_e      cond;
    pc_t        target;
    logic       ret;
    idx_op_e    idx_op;
    logic       rd_en;
    logic       wr_en;
    wa_sel_e    wa_sel;
    wd_sel_e    wd_sel;
    carry_op_e  carry_op;
    cnt_op_e    cnt_op;
    node_op_e   node_op;
    cursor_op_e cursor_op;
    rdv_op_e    rdv_op;
    st_op_e     st_op;
    logic       out_load;
  } ctl_t;

  // program steps
  localparam pc_t PC_FETCH    = pc_t'(0);
  localparam pc_t PC_DISPATCH = pc_t'(1);
  localparam pc_t PC_SET_NODE = pc_t'(2);
  localparam pc_t PC_SET_POS  = pc_t'(3);
  localparam pc_t PC_SET_WR   = pc_t'(4);
  localparam pc_t PC_RD_NODE  = pc_t'(5);
  localparam pc_t PC_RD_POS   = pc_t'(6);
  localparam pc_t PC_RD_TAKE  = pc_t'(7);
  localparam pc_t PC_SH_NODE  = pc_t'(8);
  localparam pc_t PC_SH_INIT  = pc_t'(9);
  localparam pc_t PC_SH_PRIME = pc_t'(10);
  localparam pc_t PC_SH_LOOP  = pc_t'(11);
  localparam pc_t PC_SH_END   = pc_t'(12);
  localparam pc_t PC_FN_NODE  = pc_t'(13);
  localparam pc_t PC_FN_INIT  = pc_t'(14);
  localparam pc_t PC_FN_LOOP  = pc_t'(15);
  localparam pc_t PC_FN_END   = pc_t'(16);
  localparam pc_t PC_FA_INIT  = pc_t'(17);
  localparam pc_t PC_FA_CHK   = pc_t'(18);
  localparam pc_t PC_FA_LOOP  = pc_t'(19);
  localparam pc_t PC_FA_NEXT  = pc_t'(20);
  localparam pc_t PC_FA_BACK  = pc_t'(21);
  localparam pc_t PC_LS_NODE  = pc_t'(22);
  localparam pc_t PC_LS_CHK   = pc_t'(23);
  localparam pc_t PC_LS_CUR   = pc_t'(24);
  localparam pc_t PC_LS_WR    = pc_t'(25);
  localparam pc_t PC_LS_PADQ  = pc_t'(26);
  localparam pc_t PC_LS_PADE  = pc_t'(27);
  localparam pc_t PC_LS_PAD   = pc_t'(28);
  localparam pc_t PC_LS_END   = pc_t'(29);
  localparam pc_t PC_LS_BAD   = pc_t'(30);
  localparam pc_t PC_BADN     = pc_t'(31);
  localparam pc_t PC_BADP     = pc_t'(32);
  localparam pc_t PC_FIN      = pc_t'(33);

  localparam ctl_t CTL_NOP = '{
    cond: C_NEXT, target: PC_FETCH, ret: 1'b0, idx_op: IDX_HOLD, rd_en: 1'b0,
    wr_en: 1'b0, wa_sel: WA_IDX, wd_sel: WD_COLOR, carry_op: CARRY_HOLD,
    cnt_op: CNT_HOLD, node_op: NODE_HOLD, cursor_op: CUR_HOLD, rdv_op: RDV_HOLD,
    st_op: ST_HOLD, out_load: 1'b0
  };

  function automatic addr_t slot_addr(node_t node, pos_t pos);
    slot_addr = addr_t'(ADDR_W'(node) * ADDR_W'(MAX_LEDS) + ADDR_W'(pos));
  endfunction

  // entry step of each command
  function automatic pc_t kind_entry(logic [2:0] kind);
    pc_t e;
    unique case (kind)
      K_SET:            e = PC_SET_NODE;
      K_PUSH, K_POP:    e = PC_SH_NODE;
      K_FILL:           e = PC_FN_NODE;
      K_FILL_ALL:       e = PC_FA_INIT;
      K_LIST:           e = PC_LS_NODE;
      K_READ:           e = PC_RD_NODE;
      default:          e = PC_FIN;
    endcase
    kind_entry = e;
  endfunction

  // control store
  function automatic ctl_t ucode(pc_t pc);
    ctl_t c;
    c = CTL_NOP;
    unique case (pc)
      PC_FETCH: begin
        c.cond = C_NO_REQ; c.target = PC_FETCH;
      end
      PC_DISPATCH: begin
        c.cond = C_KIND; c.idx_op = IDX_POS;
      end
      // set pixel
      PC_SET_NODE: begin c.cond = C_BAD_NODE; c.target = PC_BADN; end
      PC_SET_POS:  begin c.cond = C_BAD_POS;  c.target = PC_BADP; end
      PC_SET_WR: begin
        c.wr_en = 1'b1; c.wa_sel = WA_IDX; c.wd_sel = WD_COLOR;
        c.cond = C_ALWAYS; c.target = PC_FIN;
      end
      // read pixel
      PC_RD_NODE: begin c.cond = C_BAD_NODE; c.target = PC_BADN; end
      PC_RD_POS: begin
        c.cond = C_BAD_POS; c.target = PC_BADP; c.rd_en = 1'b1;
      end
      PC_RD_TAKE: begin
        c.rdv_op = RDV_RDATA; c.cond = C_ALWAYS; c.target = PC_FIN;
      end
      // push / pop: carry walk through the segment
      PC_SH_NODE: begin c.cond = C_BAD_NODE; c.target = PC_BADN; end
      PC_SH_INIT: begin
        c.cond = C_NL_ZERO; c.target = PC_FIN; c.idx_op = IDX_START;
        c.carry_op = CARRY_COLOR; c.cnt_op = CNT_NL;
      end
      PC_SH_PRIME: begin
        c.rd_en = 1'b1; c.idx_op = IDX_STEP;
      end
      PC_SH_LOOP: begin
        c.wr_en = 1'b1; c.wa_sel = WA_PREV; c.wd_sel = WD_CARRY;
        c.carry_op = CARRY_RDATA; c.rd_en = 1'b1; c.idx_op = IDX_STEP;
        c.cnt_op = CNT_DEC; c.cond = C_CNT_MORE; c.target = PC_SH_LOOP;
      end
      PC_SH_END: begin
        c.rdv_op = RDV_POP; c.cond = C_ALWAYS; c.target = PC_FIN;
      end
      // fill one segment
      PC_FN_NODE: begin c.cond = C_BAD_NODE; c.target = PC_BADN; end
      PC_FN_INIT: begin
        c.cond = C_NL_ZERO; c.target = PC_FIN; c.idx_op = IDX_ZERO; c.cnt_op = CNT_NL;
      end
      PC_FN_LOOP: begin
        c.wr_en = 1'b1; c.wa_sel = WA_IDX; c.wd_sel = WD_COLOR; c.idx_op = IDX_INC;
        c.cnt_op = CNT_DEC; c.cond = C_CNT_MORE; c.target = PC_FN_LOOP;
      end
      PC_FN_END: begin c.cond = C_ALWAYS; c.target = PC_FIN; end
      // fill every segment in use
      PC_FA_INIT: begin
        c.node_op = NODE_ZERO; c.idx_op = IDX_ZERO; c.cnt_op = CNT_NL;
        c.cond = C_NL_ZERO; c.target = PC_FIN;
      end
      PC_FA_CHK: begin c.cond = C_BAD_NODE; c.target = PC_FIN; end
      PC_FA_LOOP: begin
        c.wr_en = 1'b1; c.wa_sel = WA_IDX; c.wd_sel = WD_COLOR; c.idx_op = IDX_INC;
        c.cnt_op = CNT_DEC; c.cond = C_CNT_MORE; c.target = PC_FA_LOOP;
      end
      PC_FA_NEXT: begin
        c.node_op = NODE_INC; c.idx_op = IDX_ZERO; c.cnt_op = CNT_NL;
        c.cond = C_NODE_LAST; c.target = PC_FIN;
      end
      PC_FA_BACK: begin c.cond = C_ALWAYS; c.target = PC_FA_LOOP; end
      // list element
      PC_LS_NODE: begin c.node_op = NODE_LIST; end
      PC_LS_CHK:  begin c.cond = C_BAD_NODE; c.target = PC_LS_BAD; end
      PC_LS_CUR: begin
        c.idx_op = IDX_CURSOR; c.cond = C_CUR_FULL; c.target = PC_LS_PADQ;
      end
      PC_LS_WR: begin
        c.wr_en = 1'b1; c.wa_sel = WA_IDX; c.wd_sel = WD_COLOR;
        c.idx_op = IDX_INC; c.cursor_op = CUR_INC;
      end
      PC_LS_PADQ: begin c.cond = C_NO_PAD;  c.target = PC_LS_END; end
      PC_LS_PADE: begin c.cond = C_IDX_END; c.target = PC_LS_END; end
      PC_LS_PAD: begin
        c.wr_en = 1'b1; c.wa_sel = WA_IDX; c.wd_sel = WD_PAD; c.idx_op = IDX_INC;
        c.cond = C_IDX_MORE; c.target = PC_LS_PAD;
      end
      PC_LS_END: begin
        c.cursor_op = CUR_CLR_LAST; c.cond = C_ALWAYS; c.target = PC_FIN;
      end
      PC_LS_BAD: begin
        c.st_op = ST_SET_NODE; c.cursor_op = CUR_CLR_LAST;
        c.cond = C_ALWAYS; c.target = PC_FIN;
      end
      // error results
      PC_BADN: begin c.st_op = ST_SET_NODE; c.cond = C_ALWAYS; c.target = PC_FIN; end
      PC_BADP: begin c.st_op = ST_SET_POS;  c.cond = C_ALWAYS; c.target = PC_FIN; end
      // hand the result to the output register
      PC_FIN: begin
        c.cond = C_OUT_BUSY; c.target = PC_FIN; c.out_load = 1'b1; c.ret = 1'b1;
      end
      default: begin c.cond = C_ALWAYS; c.target = PC_FETCH; end
    endcase
    ucode = c;
  endfunction

endpackage

[sv/slpb_store.sv]
// ----------------------------------------------------------------------------
// slpb_store
// pixel store: one write and one registered read per cycle, cleared at reset
// through per-entry valid bits
// ----------------------------------------------------------------------------
module slpb_store (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  slpb_pkg::addr_t waddr,
  input  slpb_pkg::color_t wdata,
  input  logic            rd_en,
  input  slpb_pkg::addr_t raddr,
  output slpb_pkg::color_t rdata
);
  import slpb_pkg::*;

  color_t           mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  color_t           q_r;
  logic             q_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[waddr] <= 1'b1;
      if (rd_en) q_valid_r <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[waddr] <= wdata;
    if (rd_en) q_r <= mem_r[raddr];
  end

  // never-written entries read as zero
  assign rdata = q_valid_r ? q_r : '0;

endmodule

[sv/segmented_led_pixel_buffer.sv]
// ----------------------------------------------------------------------------
// segmented_led_pixel_buffer
// pixel colour buffer split into equal node segments, driven by a small
// microprogram: set, push, pop, fill, fill all, list stream and read
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata node,pos,colour,pad,pad_en;
//          |     |                     | tuser kind; tlast list end
//  out_    | out | out_tvalid/out_tready | tdata read colour; tuser status
//  cfg_    | in  | cfg_we              | cfg_addr register index, cfg_wdata value
//
//  one request at a time; the microprogram runs from dispatch to the result
//  step of each command
//  the push/pop walk reads one pixel and writes the previous one per cycle
//  through the single-write store
//  reset (rst_n low, synchronous) marks every pixel as zero at once
//  a result waits in the output register; the program stalls at its last
//  step while that register is still full
//
module segmented_led_pixel_buffer (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // node_sel[3:0], led_pos[6:4], pixel_color[38:7], pad_color[70:39],
  // pad_enable[71]
  input  logic [slpb_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[2:0]
  input  logic [slpb_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                               in_tlast,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_color[31:0]
  output logic [slpb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [slpb_pkg::OUT_USER_W-1:0]    out_tuser,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [slpb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [slpb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import slpb_pkg::*;

  // sequencer
  pc_t   pc_r, pc_nxt;
  ctl_t  ctl;
  logic  cond_true;

  // latched request
  logic [2:0] kind_r;
  node_t      node_r, node_nxt;
  pos_t       pos_r;
  color_t     color_r;
  color_t     pad_r;
  logic       pad_en_r;
  logic       last_r;

  // walk datapath
  cnt_t   idx_r, idx_nxt;
  cnt_t   idx_d_r;
  cnt_t   cnt_r, cnt_nxt;
  color_t carry_r, carry_nxt;
  color_t read_r, read_nxt;
  status_e status_r, status_nxt;

  // list state and configuration
  cnt_t  cursor_r, cursor_nxt;
  node_t list_node_r, list_node_nxt;
  nn_t   node_total_r;
  cnt_t  leds_r;
  nn_t   nn;
  cnt_t  nl;
  node_t list_sel;

  // output register
  logic    out_valid_r;
  color_t  out_data_r;
  status_e out_status_r;
  logic    out_busy;
  logic    out_load;

  // store port
  logic   st_wr_en;
  addr_t  st_waddr;
  color_t st_wdata;
  addr_t  st_raddr;
  color_t st_rdata;
  cnt_t   wpos;

  logic accept;

  assign in_tready = (pc_r == PC_FETCH);
  assign accept    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign ctl       = ucode(pc_r);
  assign out_load  = ctl.out_load && !out_busy;

  // effective sizes, larger settings saturate
  assign nn = (node_total_r > nn_t'(MAX_NODES)) ? nn_t'(MAX_NODES) : node_total_r;
  assign nl = (leds_r > cnt_t'(MAX_LEDS)) ? cnt_t'(MAX_LEDS) : leds_r;

  // first element of a list picks the segment, later ones follow it
  assign list_sel = (cursor_r == '0) ? node_r : list_node_r;

  // jump condition
  always_comb begin
    unique case (ctl.cond)
      C_NEXT:      cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_REQ:    cond_true = !accept;
      C_KIND:      cond_true = 1'b1;
      C_BAD_NODE:  cond_true = nn_t'(node_r) >= nn;
      C_BAD_POS:   cond_true = cnt_t'(pos_r) >= nl;
      C_NL_ZERO:   cond_true = (nl == '0);
      C_CNT_MORE:  cond_true = cnt_r > cnt_t'(1);
      C_CUR_FULL:  cond_true = cursor_r >= nl;
      C_NO_PAD:    cond_true = !(last_r && pad_en_r);
      C_IDX_END:   cond_true = idx_r >= nl;
      C_IDX_MORE:  cond_true = (nn_t'(idx_r) + nn_t'(1)) < nn_t'(nl);
      C_NODE_LAST: cond_true = (nn_t'(node_r) + nn_t'(1)) >= nn;
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_nxt = (ctl.cond == C_KIND) ? kind_entry(kind_r) : ctl.target;
    end else if (ctl.ret) begin
      pc_nxt = PC_FETCH;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  // walk index: push runs up from the front, pop runs down from the end
  always_comb begin
    unique case (ctl.idx_op)
      IDX_HOLD:   idx_nxt = idx_r;
      IDX_ZERO:   idx_nxt = '0;
      IDX_POS:    idx_nxt = cnt_t'(pos_r);
      IDX_START:  idx_nxt = (kind_r == K_POP) ? nl - cnt_t'(1) : '0;
      IDX_STEP:   idx_nxt = (kind_r == K_POP) ? idx_r - cnt_t'(1) : idx_r + cnt_t'(1);
      IDX_INC:    idx_nxt = idx_r + cnt_t'(1);
      IDX_CURSOR: idx_nxt = cursor_r;
      default:    idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (ctl.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_NL:   cnt_nxt = nl;
      CNT_DEC:  cnt_nxt = cnt_r - cnt_t'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    unique case (ctl.carry_op)
      CARRY_HOLD:  carry_nxt = carry_r;
      CARRY_COLOR: carry_nxt = color_r;
      CARRY_RDATA: carry_nxt = st_rdata;
      default:     carry_nxt = carry_r;
    endcase
  end

  always_comb begin
    list_node_nxt = list_node_r;
    if (accept) begin
      node_nxt = in_tdata[NODE_W-1:0];
    end else begin
      unique case (ctl.node_op)
        NODE_HOLD: node_nxt = node_r;
        NODE_ZERO: node_nxt = '0;
        NODE_INC:  node_nxt = node_r + node_t'(1);
        NODE_LIST: begin
          node_nxt      = list_sel;
          list_node_nxt = list_sel;
        end
        default:   node_nxt = node_r;
      endcase
    end
  end

  always_comb begin
    unique case (ctl.cursor_op)
      CUR_HOLD:     cursor_nxt = cursor_r;
      CUR_INC:      cursor_nxt = cursor_r + cnt_t'(1);
      CUR_CLR_LAST: cursor_nxt = last_r ? '0 : cursor_r;
      default:      cursor_nxt = cursor_r;
    endcase
  end

  // result value and status, cleared as each request comes in
  always_comb begin
    read_nxt   = read_r;
    status_nxt = status_r;
    if (accept) begin
      read_nxt   = '0;
      status_nxt = ST_DONE;
    end else begin
      unique case (ctl.rdv_op)
        RDV_HOLD:  read_nxt = read_r;
        RDV_RDATA: read_nxt = st_rdata;
        RDV_POP:   read_nxt = (kind_r == K_POP) ? carry_r : read_r;
        default:   read_nxt = read_r;
      endcase
      unique case (ctl.st_op)
        ST_HOLD:     status_nxt = status_r;
        ST_SET_NODE: status_nxt = ST_BAD_NODE;
        ST_SET_POS:  status_nxt = ST_BAD_POS;
        default:     status_nxt = status_r;
      endcase
    end
  end

  // store addressing: walk writes trail the read by one step
  assign wpos     = (ctl.wa_sel == WA_PREV) ? idx_d_r : idx_r;
  assign st_wr_en = ctl.wr_en;
  assign st_waddr = slot_addr(node_r, wpos[POS_W-1:0]);
  assign st_raddr = slot_addr(node_r, idx_r[POS_W-1:0]);

  always_comb begin
    unique case (ctl.wd_sel)
      WD_COLOR: st_wdata = color_r;
      WD_PAD:   st_wdata = pad_r;
      WD_CARRY: st_wdata = carry_r;
      default:  st_wdata = color_r;
    endcase
  end

  slpb_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (st_wr_en),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .rd_en (ctl.rd_en),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_FETCH;
      cursor_r     <= '0;
      list_node_r  <= '0;
      node_total_r <= nn_t'(MAX_NODES);
      leds_r       <= cnt_t'(MAX_LEDS);
      out_valid_r  <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cursor_r    <= cursor_nxt;
      list_node_r <= list_node_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_addr))
          REG_NODE_TOTAL: node_total_r <= cfg_wdata[NN_W-1:0];
          REG_LEDS:       leds_r       <= cfg_wdata[CNT_W-1:0];
        endcase
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_tuser;
      pos_r    <= in_tdata[NODE_W +: POS_W];
      color_r  <= in_tdata[NODE_W + POS_W +: COLOR_BITS];
      pad_r    <= in_tdata[NODE_W + POS_W + COLOR_BITS +: COLOR_BITS];
      pad_en_r <= in_tdata[NODE_W + POS_W + 2 * COLOR_BITS];
      last_r   <= in_tlast;
    end
    node_r   <= node_nxt;
    idx_r    <= idx_nxt;
    idx_d_r  <= idx_r;
    cnt_r    <= cnt_nxt;
    carry_r  <= carry_nxt;
    read_r   <= read_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_data_r   <= read_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // every write stays inside the segment's pixels in use
  a_write_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_en |-> wpos < nl)
    else $error("store write outside segment");

  // the walk never reads the word it is writing
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (st_wr_en && ctl.rd_en) |-> st_waddr != st_raddr)
    else $error("store read and write collide");

  // list cursor never passes a full segment
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= cnt_t'(MAX_LEDS))
    else $error("list cursor out of range");

  // handing over a result ends the program
  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> pc_r == PC_FETCH)
    else $error("result loaded without return to fetch");
`endif

endmodule
